// File: design/utd_pkg.sv
// Shared types and constants for the UTF-8 to UTF-16 decoder.
`timescale 1ns / 1ps

package utd_pkg;

   // Byte classification constants
   localparam logic [7:0] ASCII_LIMIT   = 8'h80;  // first non-ASCII byte
   localparam logic [7:0] LEAD_MASK     = 8'hC0;  // top two bits of a byte
   localparam logic [7:0] CONT_PATTERN  = 8'h80;  // 10xxxxxx
   localparam logic [7:0] LEAD3_MIN     = 8'hE0;  // first three-byte lead
   localparam logic [7:0] LEAD4_MIN     = 8'hF0;  // first four-byte lead
   localparam logic [7:0] BAD_LEAD_MIN  = 8'hF8;  // leads from here on are illegal
   localparam logic [4:0] OVERLONG2_MASK = 5'h1E; // C0/C1 carry no bits here
   localparam logic [7:0] CONT_BITS     = 8'h3F;
   localparam logic [7:0] CHECK3_BIT    = 8'h20;  // first-continuation check, 3-byte
   localparam logic [7:0] CHECK4_BITS   = 8'h30;  // first-continuation check, 4-byte
   localparam logic [2:0] LEAD4_MAX_PAYLOAD = 3'd4;

   // Code point constants
   localparam int unsigned CP_W = 21;
   localparam logic [CP_W-1:0] LEAD3_SURR_PAYLOAD = 21'h0000D; // ED lead
   localparam logic [CP_W-1:0] LEAD4_TOP_PAYLOAD  = 21'h00004; // F4 lead
   localparam logic [CP_W-1:0] SUPP_BASE  = 21'h10000;
   localparam logic [15:0]     HIGH_SURR  = 16'hD800;
   localparam logic [15:0]     LOW_SURR   = 16'hDC00;
   localparam logic [15:0]     SURR_BITS  = 16'h03FF;

   // Sequence lengths (continuation counts)
   localparam logic [1:0] SEQ_LEN2 = 2'd1;
   localparam logic [1:0] SEQ_LEN3 = 2'd2;
   localparam logic [1:0] SEQ_LEN4 = 2'd3;

   // Result queue sizing
   localparam int unsigned BUF_DEPTH = 4;
   localparam int unsigned BUF_PTR_W = $clog2(BUF_DEPTH);
   localparam int unsigned BUF_CNT_W = $clog2(BUF_DEPTH + 1);

   typedef enum logic [1:0] {
      STATUS_OK         = 2'd0,
      STATUS_INVALID    = 2'd1,
      STATUS_INCOMPLETE = 2'd2
   } status_type;

   typedef struct packed {
      logic [15:0] code_word;
      status_type  status;
      logic        run_last;
   } rsp_item_type;

   // Results produced by one input transaction
   typedef struct packed {
      logic [1:0]   count;
      rsp_item_type item0;
      rsp_item_type item1;
   } step_out_type;

endpackage

// File: design/utd_channels.sv
// Valid/ready channel interfaces for request bytes and response words.
`timescale 1ns / 1ps

interface utd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       end_of_input;

   modport source (output valid, output in_byte, output end_of_input, input ready);
   modport sink   (input valid, input in_byte, input end_of_input, output ready);
endinterface

interface utd_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] code_word;
   logic [1:0]  status;
   logic        run_last;

   modport source (output valid, output code_word, output status, output run_last,
                   input ready);
   modport sink   (input valid, input code_word, input status, input run_last,
                   output ready);
endinterface

// File: design/utd_step.sv
// Sequence state registers and per-byte decode logic.
`timescale 1ns / 1ps

module utd_step (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic [7:0]            in_byte,
   input  logic                  end_of_input,
   output utd_pkg::step_out_type step_out
);
   import utd_pkg::*;

   logic [CP_W-1:0] accum_ff, accum_in;
   logic [1:0]      bytes_left_ff, bytes_left_in;
   logic [1:0]      seq_length_ff, seq_length_in;
   logic            first_pending_ff, first_pending_in;
   logic            error_ff, error_in;
   logic            drop_ff, drop_in;

   logic [CP_W-1:0] lead_payload;
   logic [1:0]      lead_len;
   logic            lead_err;
   logic            cont_err;
   logic [CP_W-1:0] cont_accum;
   logic [1:0]      cont_left;
   logic [CP_W-1:0] supp_off;
   rsp_item_type    err_invalid, err_incomplete;

   // Lead byte decode
   always_comb begin
      lead_payload = '0;
      lead_len     = SEQ_LEN2;
      lead_err     = 1'b0;
      if (in_byte < LEAD3_MIN) begin
         lead_payload = CP_W'(in_byte[4:0]);
         lead_len     = SEQ_LEN2;
         lead_err     = (in_byte[4:0] & OVERLONG2_MASK) == 5'd0;
      end else if (in_byte < LEAD4_MIN) begin
         lead_payload = CP_W'(in_byte[3:0]);
         lead_len     = SEQ_LEN3;
      end else begin
         lead_payload = CP_W'(in_byte[2:0]);
         lead_len     = SEQ_LEN4;
         lead_err     = in_byte[2:0] > LEAD4_MAX_PAYLOAD;
      end
   end

   // Continuation byte checks and accumulation
   always_comb begin
      cont_err = error_ff;
      if (first_pending_ff) begin
         if (seq_length_ff == SEQ_LEN3) begin
            if (accum_ff == '0 && (in_byte & CHECK3_BIT) == 8'd0)
               cont_err = 1'b1;   // overlong three-byte form
            if (accum_ff == LEAD3_SURR_PAYLOAD && (in_byte & CHECK3_BIT) != 8'd0)
               cont_err = 1'b1;   // encoded surrogate
         end else begin
            if (accum_ff == '0 && (in_byte & CHECK4_BITS) == 8'd0)
               cont_err = 1'b1;   // overlong four-byte form
            if (accum_ff == LEAD4_TOP_PAYLOAD && (in_byte & CHECK4_BITS) != 8'd0)
               cont_err = 1'b1;   // above the last code point
         end
      end
      if ((in_byte & LEAD_MASK) != CONT_PATTERN)
         cont_err = 1'b1;
      cont_accum = {accum_ff[CP_W-7:0], in_byte[5:0]};
      cont_left  = bytes_left_ff - 2'd1;
      supp_off   = cont_accum - SUPP_BASE;
   end

   assign err_invalid    = '{code_word: 16'd0, status: STATUS_INVALID, run_last: 1'b1};
   assign err_incomplete = '{code_word: 16'd0, status: STATUS_INCOMPLETE, run_last: 1'b1};

   // Next state and results for the accepted transaction
   always_comb begin
      accum_in         = accum_ff;
      bytes_left_in    = bytes_left_ff;
      seq_length_in    = seq_length_ff;
      first_pending_in = first_pending_ff;
      error_in         = error_ff;
      drop_in          = drop_ff;
      step_out         = '0;
      if (accept) begin
         if (drop_ff) begin
            if (end_of_input) drop_in = 1'b0;
         end else if (bytes_left_ff == 2'd0) begin
            if (in_byte < ASCII_LIMIT) begin
               step_out.count = 2'd1;
               step_out.item0 = '{code_word: 16'(in_byte), status: STATUS_OK,
                                  run_last: 1'b1};
            end else if ((in_byte & LEAD_MASK) != LEAD_MASK || in_byte >= BAD_LEAD_MIN) begin
               // stray continuation or illegal lead
               step_out.count = 2'd1;
               step_out.item0 = err_invalid;
               drop_in        = !end_of_input;
            end else if (end_of_input) begin
               step_out.count = 2'd1;
               step_out.item0 = err_incomplete;
            end else begin
               accum_in         = lead_payload;
               bytes_left_in    = lead_len;
               seq_length_in    = lead_len;
               first_pending_in = lead_len >= SEQ_LEN3;
               error_in         = lead_err;
            end
         end else begin
            accum_in         = cont_accum;
            bytes_left_in    = cont_left;
            first_pending_in = 1'b0;
            error_in         = cont_err;
            if (cont_left != 2'd0) begin
               if (end_of_input) begin
                  step_out.count = 2'd1;
                  step_out.item0 = err_incomplete;
               end
            end else if (cont_err) begin
               step_out.count = 2'd1;
               step_out.item0 = err_invalid;
               drop_in        = !end_of_input;
            end else if (cont_accum < SUPP_BASE) begin
               step_out.count = 2'd1;
               step_out.item0 = '{code_word: cont_accum[15:0], status: STATUS_OK,
                                  run_last: 1'b1};
            end else begin
               // surrogate pair
               step_out.count = 2'd2;
               step_out.item0 = '{code_word: HIGH_SURR | (16'(supp_off[19:10]) & SURR_BITS),
                                  status: STATUS_OK, run_last: 1'b0};
               step_out.item1 = '{code_word: LOW_SURR | (16'(supp_off[9:0]) & SURR_BITS),
                                  status: STATUS_OK, run_last: 1'b1};
            end
            // any emitted result or error closes the sequence
            if (step_out.count != 2'd0) begin
               accum_in         = '0;
               bytes_left_in    = 2'd0;
               seq_length_in    = 2'd0;
               first_pending_in = 1'b0;
               error_in         = 1'b0;
            end
         end
      end
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         accum_ff         <= '0;
         bytes_left_ff    <= 2'd0;
         seq_length_ff    <= 2'd0;
         first_pending_ff <= 1'b0;
         error_ff         <= 1'b0;
         drop_ff          <= 1'b0;
      end else begin
         accum_ff         <= accum_in;
         bytes_left_ff    <= bytes_left_in;
         seq_length_ff    <= seq_length_in;
         first_pending_ff <= first_pending_in;
         error_ff         <= error_in;
         drop_ff          <= drop_in;
      end
   end

endmodule

// File: design/utd_rsp_buffer.sv
// Small result queue: takes up to two results a cycle, delivers one while the receiver is ready.
`timescale 1ns / 1ps

module utd_rsp_buffer (
   input  logic                  clock,
   input  logic                  reset,
   input  utd_pkg::step_out_type push,
   output logic                  room,
   utd_rsp_if.source             rsp
);
   import utd_pkg::*;

   rsp_item_type            entry_ff [BUF_DEPTH];
   logic [BUF_PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [BUF_PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [BUF_CNT_W-1:0]    count_ff, count_in;
   logic [BUF_PTR_W-1:0]    wr_ptr_next;
   logic                    pop;
   rsp_item_type            head;

   // Room for a full surrogate pair
   assign room = count_ff <= BUF_CNT_W'(BUF_DEPTH - 2);

   assign pop         = rsp.valid && rsp.ready;
   assign wr_ptr_next = wr_ptr_ff + BUF_PTR_W'(1);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + BUF_PTR_W'(push.count);
      rd_ptr_in = rd_ptr_ff + BUF_PTR_W'(pop);
      count_in  = count_ff + BUF_CNT_W'(push.count) - BUF_CNT_W'(pop);
   end

   // Pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (push.count != 2'd0) entry_ff[wr_ptr_ff] <= push.item0;
      if (push.count == 2'd2) entry_ff[wr_ptr_next] <= push.item1;
   end

   // Head of queue drives the response channel
   assign head          = entry_ff[rd_ptr_ff];
   assign rsp.valid     = count_ff != '0;
   assign rsp.code_word = head.code_word;
   assign rsp.status    = head.status;
   assign rsp.run_last  = head.run_last;

endmodule

// File: design/utf8_to_utf16_decoder_core.sv
// UTF-8 to UTF-16 stream decoder, top level.
`timescale 1ns / 1ps

// Accepts one UTF-8 byte per cycle on req_chan and delivers UTF-16 code
// units on rsp_chan. Every byte is decoded in the cycle it is accepted: the
// sequence state updates at that edge and any results enter a four-entry
// result queue, so the first result is visible on the next cycle. A code
// point at or above 0x10000 yields a surrogate pair, sent as two response
// words; all other bytes yield zero or one result. req_chan.ready
// is high whenever the queue has room for two results, so with rsp_chan
// ready held high the block sustains one byte per cycle. Malformed or
// truncated input gives one error transaction (status 1 or 2, code word 0),
// and bytes after an error are discarded up to the end-of-input byte.

module utf8_to_utf16_decoder_core (
   input  logic      clock,
   input  logic      reset,
   utd_req_if.sink   req_chan,
   utd_rsp_if.source rsp_chan
);
   import utd_pkg::*;

   logic         accept;
   logic         room;
   step_out_type step_out;

   assign req_chan.ready = room;
   assign accept         = req_chan.valid && req_chan.ready;

   // Byte decode and sequence state
   utd_step u_step (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .in_byte      (req_chan.in_byte),
      .end_of_input (req_chan.end_of_input),
      .step_out     (step_out)
   );

   // Result queue
   utd_rsp_buffer u_rsp_buffer (
      .clock (clock),
      .reset (reset),
      .push  (step_out),
      .room  (room),
      .rsp   (rsp_chan)
   );

endmodule

// File: verif/testbench.sv
// Self-checking testbench for the UTF-8 to UTF-16 stream decoder.
`timescale 1ns / 1ps

module testbench;
   import utd_pkg::*;

   localparam int unsigned WATCHDOG_CYCLES = 200000;
   localparam int unsigned DRAIN_SLACK     = 4;
   localparam int unsigned MAX_REPORTS     = 40;

   // Receiver stall modes
   localparam int unsigned STALL_NONE     = 0;
   localparam int unsigned STALL_RANDOM   = 1;
   localparam int unsigned STALL_PERIODIC = 2;

   logic clock;
   logic reset;

   utd_req_if req_chan ();
   utd_rsp_if rsp_chan ();

   utf8_to_utf16_decoder_core u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Expected UTF-16 units, oldest first
   rsp_item_type expected_units[$];
   logic [7:0]   pending_bytes[$];

   // Decoder state as predicted from accepted bytes
   logic [20:0] cp_acc     = '0;
   logic [1:0]  cont_left  = '0;
   logic [1:0]  cont_total = '0;
   logic        first_cont = 1'b0;
   logic        seq_bad    = 1'b0;
   logic        dropping   = 1'b0;

   int unsigned bytes_decoded   = 0;
   int unsigned fail_count      = 0;
   int unsigned words_seen      = 0;
   int unsigned invalid_seen    = 0;
   int unsigned incomplete_seen = 0;
   int unsigned pair_count      = 0;
   int unsigned pause_count     = 0;

   // Sender pacing
   bit          pacing_on  = 1'b1;
   int unsigned burst_left = 0;

   // Long receiver hold-off, requested by the test flow
   int unsigned hold_request_count = 0;
   int unsigned hold_length        = 0;

   rsp_item_type want;

   // Clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog
   initial begin
      repeat (WATCHDOG_CYCLES) @(posedge clock);
      $display("FAILURE");
      $finish;
   end

   function automatic rsp_item_type make_unit(input logic [15:0] w, input status_type s,
                                              input logic l);
      rsp_item_type u;
      u.code_word = w;
      u.status    = s;
      u.run_last  = l;
      return u;
   endfunction

   function automatic logic [7:0] rand_byte(input logic [7:0] lo, input logic [7:0] hi);
      int unsigned v;
      v = $urandom_range(int'(hi), int'(lo));
      return v[7:0];
   endfunction

   function automatic void clear_sequence();
      cp_acc     = '0;
      cont_left  = '0;
      cont_total = '0;
      first_cont = 1'b0;
      seq_bad    = 1'b0;
   endfunction

   // Append one unit to the tail of the expected queue
   function automatic void expect_unit(input rsp_item_type u);
      expected_units.insert(expected_units.size(), u);
   endfunction

   // One error transaction, then drop the rest of the string unless this was its end
   task automatic flag_error(input status_type s, input logic eoi);
      expect_unit(make_unit(16'h0000, s, 1'b1));
      clear_sequence();
      dropping = !eoi;
   endtask

   // Predict the UTF-16 units caused by one accepted byte
   task automatic decode_byte(input logic [7:0] b, input logic eoi);
      logic [20:0] supp;
      if (dropping) begin
         if (eoi)
            dropping = 1'b0;
         return;
      end
      bytes_decoded++;

      // No open sequence: ASCII, lead or illegal byte
      if (cont_left == 2'd0) begin
         if (b < 8'h80) begin
            expect_unit(make_unit({8'h00, b}, STATUS_OK, 1'b1));
            return;
         end
         if (b[7:6] != 2'b11 || b >= 8'hF8) begin
            flag_error(STATUS_INVALID, eoi);
            return;
         end
         seq_bad = 1'b0;
         if (b < 8'hE0) begin
            cp_acc     = {16'd0, b[4:0]};
            cont_total = SEQ_LEN2;
            seq_bad    = (b[4:1] == 4'd0);      // C0/C1 overlong
         end else if (b < 8'hF0) begin
            cp_acc     = {17'd0, b[3:0]};
            cont_total = SEQ_LEN3;
         end else begin
            cp_acc     = {18'd0, b[2:0]};
            cont_total = SEQ_LEN4;
            seq_bad    = (b[2:0] > 3'd4);       // F5..F7 above max
         end
         cont_left  = cont_total;
         first_cont = (cont_total != SEQ_LEN2);
         if (eoi)
            flag_error(STATUS_INCOMPLETE, 1'b1);
         return;
      end

      // Range checks that depend on the lead and the first continuation
      if (first_cont) begin
         if (cont_total == SEQ_LEN3) begin
            if (cp_acc == 21'd0 && !b[5])
               seq_bad = 1'b1;                  // E0 overlong
            if (cp_acc == 21'd13 && b[5])
               seq_bad = 1'b1;                  // ED surrogate
         end else begin
            if (cp_acc == 21'd0 && b[5:4] == 2'b00)
               seq_bad = 1'b1;                  // F0 overlong
            if (cp_acc == 21'd4 && b[5:4] != 2'b00)
               seq_bad = 1'b1;                  // F4 above max
         end
         first_cont = 1'b0;
      end
      if (b[7:6] != 2'b10)
         seq_bad = 1'b1;
      cp_acc    = {cp_acc[14:0], b[5:0]};
      cont_left = cont_left - 2'd1;

      if (cont_left != 2'd0) begin
         if (eoi)
            flag_error(STATUS_INCOMPLETE, 1'b1);
         return;
      end
      if (seq_bad) begin
         flag_error(STATUS_INVALID, eoi);
         return;
      end
      if (cp_acc < SUPP_BASE) begin
         expect_unit(make_unit(cp_acc[15:0], STATUS_OK, 1'b1));
      end else begin
         supp = cp_acc - SUPP_BASE;
         expect_unit(make_unit(HIGH_SURR | {6'd0, supp[19:10]}, STATUS_OK, 1'b0));
         expect_unit(make_unit(LOW_SURR | {6'd0, supp[9:0]}, STATUS_OK, 1'b1));
         pair_count++;
      end
      clear_sequence();
   endtask

   // Drive one byte and hold it until the handshake completes
   task automatic send_byte(input logic [7:0] b, input logic eoi);
      req_chan.valid        <= 1'b1;
      req_chan.in_byte      <= b;
      req_chan.end_of_input <= eoi;
      do
         @(negedge clock);
      while (!req_chan.ready);
      decode_byte(b, eoi);
      @(posedge clock);
   endtask

   task automatic idle(input int unsigned n);
      req_chan.valid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   // Bursts of random length separated by random gaps
   task automatic pace();
      int unsigned gap;
      if (!pacing_on)
         return;
      if (burst_left == 0) begin
         burst_left = $urandom_range(40, 1);
         gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(6, 1);
         if (gap != 0)
            idle(gap);
      end
      burst_left--;
   endtask

   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      while (expected_units.size() != 0)
         @(posedge clock);
      repeat (DRAIN_SLACK) @(posedge clock);
   endtask

   task automatic queue_byte(input logic [7:0] b);
      pending_bytes.insert(pending_bytes.size(), b);
   endtask

   // Append the UTF-8 encoding of a code point
   task automatic add_cp(input int unsigned cp);
      logic [20:0] c;
      c = cp[20:0];
      if (cp < 'h80) begin
         queue_byte({1'b0, c[6:0]});
      end else if (cp < 'h800) begin
         queue_byte({3'b110, c[10:6]});
         queue_byte({2'b10, c[5:0]});
      end else if (cp < 'h10000) begin
         queue_byte({4'b1110, c[15:12]});
         queue_byte({2'b10, c[11:6]});
         queue_byte({2'b10, c[5:0]});
      end else begin
         queue_byte({5'b11110, c[20:18]});
         queue_byte({2'b10, c[17:12]});
         queue_byte({2'b10, c[11:6]});
         queue_byte({2'b10, c[5:0]});
      end
   endtask

   function automatic int unsigned random_cp();
      int unsigned v;
      if ($urandom_range(15) == 0) begin
         case ($urandom_range(8))
            0:       v = 'h7F;
            1:       v = 'h80;
            2:       v = 'h7FF;
            3:       v = 'h800;
            4:       v = 'hD7FF;
            5:       v = 'hE000;
            6:       v = 'hFFFF;
            7:       v = 'h10000;
            default: v = 'h10FFFF;
         endcase
         return v;
      end
      case ($urandom_range(3))
         0: v = $urandom_range('h7F, 0);
         1: v = $urandom_range('h7FF, 'h80);
         2: begin
            v = $urandom_range('hFFFF, 'h800);
            if (v >= 'hD800 && v <= 'hDFFF)
               v -= 'h800;
         end
         default: v = $urandom_range('h10FFFF, 'h10000);
      endcase
      return v;
   endfunction

   // One malformed character of a random kind
   task automatic add_bad_char();
      case ($urandom_range(7))
         0: queue_byte(rand_byte(8'h80, 8'hBF));          // stray continuation
         1: queue_byte(rand_byte(8'hF8, 8'hFF));          // illegal lead
         2: begin                                          // two-byte overlong
            queue_byte(rand_byte(8'hC0, 8'hC1));
            queue_byte(rand_byte(8'h80, 8'hBF));
         end
         3: begin                                          // three-byte overlong
            queue_byte(8'hE0);
            queue_byte(rand_byte(8'h80, 8'h9F));
            queue_byte(rand_byte(8'h80, 8'hBF));
         end
         4: begin                                          // four-byte overlong
            queue_byte(8'hF0);
            queue_byte(rand_byte(8'h80, 8'h8F));
            queue_byte(rand_byte(8'h80, 8'hBF));
            queue_byte(rand_byte(8'h80, 8'hBF));
         end
         5: begin                                          // encoded surrogate
            queue_byte(8'hED);
            queue_byte(rand_byte(8'hA0, 8'hBF));
            queue_byte(rand_byte(8'h80, 8'hBF));
         end
         6: begin                                          // above 0x10FFFF
            if ($urandom_range(1) == 0) begin
               queue_byte(8'hF4);
               queue_byte(rand_byte(8'h90, 8'hBF));
            end else begin
               queue_byte(rand_byte(8'hF5, 8'hF7));
               queue_byte(rand_byte(8'h80, 8'hBF));
            end
            queue_byte(rand_byte(8'h80, 8'hBF));
            queue_byte(rand_byte(8'h80, 8'hBF));
         end
         default: begin                                    // non-continuation inside
            queue_byte(rand_byte(8'hC2, 8'hDF));
            if ($urandom_range(1) == 0)
               queue_byte(rand_byte(8'h00, 8'h7F));
            else
               queue_byte(rand_byte(8'hC0, 8'hFF));
         end
      endcase
   endtask

   // A string of random characters, some of them broken
   task automatic build_string(input int unsigned bad_pct);
      int unsigned nchars;
      int unsigned pos;
      logic [7:0]  dropped;
      nchars = $urandom_range(8, 1);
      for (int k = 0; k < nchars; k++) begin
         if ($urandom_range(99) < bad_pct)
            add_bad_char();
         else
            add_cp(random_cp());
      end
      if ($urandom_range(99) < bad_pct) begin
         case ($urandom_range(2))
            0: if (pending_bytes.size() > 1)
               dropped = pending_bytes.pop_back();
            1: begin
               pos = $urandom_range(pending_bytes.size() - 1);
               pending_bytes[pos] = rand_byte(8'h00, 8'hFF);
            end
            default: queue_byte(rand_byte(8'h80, 8'hFF));
         endcase
      end
   endtask

   // Send the queued string, end-of-input on its last byte
   task automatic send_pending(input int pause_at);
      int n;
      n = pending_bytes.size();
      for (int i = 0; i < n; i++) begin
         if (i == pause_at) begin
            wait_drained();
            pause_count++;
         end
         pace();
         send_byte(pending_bytes[i], i == n - 1);
      end
      pending_bytes.delete();
   endtask

   // Result checker: one transaction per negedge with valid and ready high
   always @(negedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_units.size() == 0) begin
            if (fail_count < MAX_REPORTS)
               $display("%0t: expected no transaction, got word=%h status=%0d last=%b",
                        $time, rsp_chan.code_word, rsp_chan.status, rsp_chan.run_last);
            fail_count++;
         end else begin
            want = expected_units.pop_front();
            if (rsp_chan.code_word !== want.code_word || rsp_chan.status !== want.status ||
                rsp_chan.run_last !== want.run_last) begin
               if (fail_count < MAX_REPORTS)
                  $display("%0t: mismatch expected word=%h status=%0d last=%b, got word=%h status=%0d last=%b",
                           $time, want.code_word, want.status, want.run_last,
                           rsp_chan.code_word, rsp_chan.status, rsp_chan.run_last);
               fail_count++;
            end
            case (want.status)
               STATUS_OK:      words_seen++;
               STATUS_INVALID: invalid_seen++;
               default:        incomplete_seen++;
            endcase
         end
      end
   end

   // Receiver: stretches of free flow, random stalls or a fixed pattern
   initial begin : rsp_stall_gen
      int unsigned stretch_left;
      int unsigned mode;
      int unsigned stall_pct;
      int unsigned period;
      int unsigned hold_left;
      int unsigned hold_seen;
      int unsigned tick;
      rsp_chan.ready = 1'b0;
      stretch_left   = 0;
      mode           = STALL_NONE;
      stall_pct      = 0;
      period         = 1;
      hold_left      = 0;
      hold_seen      = 0;
      tick           = 0;
      forever begin
         @(posedge clock);
         tick++;
         if (hold_seen != hold_request_count) begin
            hold_seen = hold_request_count;
            hold_left = hold_length;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            if (stretch_left == 0) begin
               stretch_left = $urandom_range(80, 10);
               mode         = $urandom_range(STALL_PERIODIC, STALL_NONE);
               stall_pct    = $urandom_range(85, 10);
               period       = $urandom_range(5, 2);
            end
            stretch_left--;
            case (mode)
               STALL_NONE:   rsp_chan.ready <= 1'b1;
               STALL_RANDOM: rsp_chan.ready <= ($urandom_range(99) >= stall_pct);
               default:      rsp_chan.ready <= (tick % period == 0);
            endcase
         end
      end
   end

   // ASCII extremes and some of the code point boundaries
   task automatic test_valid_chars();
      queue_byte(8'h00);
      queue_byte(8'h7F);
      send_pending(-1);
      add_cp('h80);
      add_cp('hFFFF);
      add_cp('h10FFFF);
      send_pending(-1);
   endtask

   // Each kind of invalid input, including dropping after an error
   task automatic test_malformed();
      queue_byte(8'h80);                       // stray continuation, rest dropped
      queue_byte(8'h41);
      queue_byte(8'h42);
      send_pending(-1);
      queue_byte(8'hFF);                       // illegal lead
      send_pending(-1);
      queue_byte(8'hC0);                       // overlong
      queue_byte(8'h80);
      send_pending(-1);
      queue_byte(8'hED);                       // surrogate
      queue_byte(8'hA0);
      queue_byte(8'h80);
      send_pending(-1);
      queue_byte(8'hF4);                       // above max
      queue_byte(8'h90);
      queue_byte(8'h80);
      queue_byte(8'h80);
      send_pending(-1);
      queue_byte(8'hC3);                       // non-continuation inside sequence
      queue_byte(8'h41);
      send_pending(-1);
   endtask

   // Truncated sequence whose latched overlong error loses to incomplete
   task automatic test_incomplete();
      queue_byte(8'hE0);
      queue_byte(8'h80);
      send_pending(-1);
   endtask

   task automatic test_random_strings(input int unsigned n, input int unsigned bad_pct);
      int unsigned start;
      start = bytes_decoded;
      while (bytes_decoded - start < n) begin
         build_string(bad_pct);
         send_pending(-1);
      end
   endtask

   // Hold the receiver off while bytes keep coming so the input stalls
   task automatic test_fill_and_stall();
      for (int r = 0; r < 3; r++) begin
         hold_length        <= $urandom_range(200, 100);
         hold_request_count <= hold_request_count + 1;
         pacing_on = 1'b0;
         repeat (6) begin
            build_string(5);
            send_pending(-1);
         end
         wait_drained();
      end
      pacing_on = 1'b1;
   endtask

   // Sender pauses mid-string until all results are in
   task automatic test_pause_drain();
      int pause_at;
      repeat (10) begin
         build_string(20);
         pause_at = $urandom_range(pending_bytes.size() - 1);
         send_pending(pause_at);
      end
   endtask

   // Raw random bytes
   task automatic test_random_noise(input int unsigned n);
      int unsigned start;
      start = bytes_decoded;
      while (bytes_decoded - start < n) begin
         repeat ($urandom_range(6, 1)) queue_byte(rand_byte(8'h00, 8'hFF));
         send_pending(-1);
      end
   endtask

   initial begin : main_flow
      req_chan.valid        = 1'b0;
      req_chan.in_byte      = 8'h00;
      req_chan.end_of_input = 1'b0;
      reset                 = 1'b1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_valid_chars();
      test_malformed();
      test_incomplete();
      test_random_strings(700, 15);
      test_fill_and_stall();
      test_pause_drain();
      test_random_noise(250);
      wait_drained();

      $display("Covered %0d decoded bytes: %0d code units (%0d surrogate pairs),",
               bytes_decoded, words_seen, pair_count);
      $display("%0d invalid and %0d incomplete reports, %0d mid-string drain pauses.",
               invalid_seen, incomplete_seen, pause_count);
      if (fail_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
